@@ rtl/gbns_pkg.sv @@
package gbns_pkg;

  // Event codes carried in the low two bits of an input item.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // Sequencer states of the back end.
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Fixed field widths.
  localparam int unsigned AckW     = 16;
  localparam int unsigned FrameW   = 16;
  localparam int unsigned WinRegW  = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 24;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TOTAL_FRAMES  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 2'd2;

  // Configuration reset values.
  localparam logic [WinRegW-1:0] WindowSizeRst   = 7'd4;
  localparam logic [15:0]        TotalFramesRst  = 16'd10;
  localparam logic [15:0]        TimeoutTicksRst = 16'd2;

  // Result kinds.
  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // One classified event waiting in the queue.
  typedef struct packed {
    op_t            op;
    logic [AckW-1:0] ack;
  } event_t;

  // Configuration registers as seen by the back end.
  typedef struct packed {
    logic [WinRegW-1:0] win_limit;
    logic [15:0]        frame_total;
    logic [15:0]        timeout_ticks;
  } cfg_t;

endpackage

@@ rtl/gbns_front.sv @@
module gbns_front
  import gbns_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [InDataW-1:0] s_tdata,   // op [1:0], ack_number [17:2]
  output logic               ev_valid,
  output event_t             ev,
  input  logic               ev_pop
);

  localparam int unsigned Depth = 2;

  event_t      queue [Depth];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic [1:0]  op_raw;
  logic        known;
  logic        push;
  logic        pop;

  // Classify the incoming item: an unknown event code is taken and dropped.
  assign op_raw   = s_tdata[1:0];
  assign known    = (op_raw == OP_START) || (op_raw == OP_ACK) || (op_raw == OP_TICK);
  assign s_tready = (count != 2'(Depth));
  assign push     = s_tvalid && s_tready && known;
  assign pop      = ev_pop && ev_valid;

  assign ev_valid = (count != 2'd0);
  assign ev       = queue[rd_ptr];

  // Occupancy count.
  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // Queue pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{op: op_t'(op_raw), ack: s_tdata[AckW+1:2]};
    end
  end

endmodule

@@ rtl/gbns_back.sv @@
module gbns_back
  import gbns_pkg::*;
#(
  parameter int SEQ_WIDTH  = 16,
  parameter int MAX_WINDOW = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              ev_valid,
  input  event_t            ev,
  output logic              ev_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [FrameW-1:0] m_tdata,  // frame_number [15:0]
  output logic              m_tuser,  // kind [0]
  output logic              m_tlast
);

  // Frame numbers never exceed the usable sequence space, capped by the
  // 16-bit total register.
  localparam int SW  = (SEQ_WIDTH < 16) ? SEQ_WIDTH : 16;
  localparam int SW1 = SW + 1;
  localparam int WW  = $clog2(MAX_WINDOW + 1);
  localparam logic [15:0] SeqCap = 16'((64'd1 << SW) - 64'd1);

  state_t            state, state_next;
  logic [SW-1:0]     base, base_next;
  logic [SW-1:0]     nxt, nxt_next;
  logic [15:0]       idle, idle_next;
  logic              active, active_next;
  logic              o_valid_next;
  logic [FrameW-1:0] o_data_next;
  logic              o_user_next;
  logic              o_last_next;

  logic [SW-1:0]     tot;
  logic [WW-1:0]     win;
  logic [SW:0]       limit;
  logic [SW:0]       nxt_inc;
  logic [16:0]       ack_inc;
  logic [SW-1:0]     ack_base;
  logic [15:0]       idle_sat;
  logic              out_free;
  logic              load;
  logic              load_kind;
  logic [SW-1:0]     load_frame;
  logic              load_last;

  // Effective total and window, and the window limit.
  always_comb begin
    if (cfg.frame_total > SeqCap) begin
      tot = SW'(SeqCap);
    end else begin
      tot = SW'(cfg.frame_total);
    end
    if (cfg.win_limit == '0) begin
      win = WW'(1);
    end else if (cfg.win_limit > WinRegW'(MAX_WINDOW)) begin
      win = WW'(MAX_WINDOW);
    end else begin
      win = WW'(cfg.win_limit);
    end
  end

  assign limit    = {1'b0, base} + SW1'(win);
  assign nxt_inc  = {1'b0, nxt} + SW1'(1);
  assign ack_inc  = {1'b0, ev.ack} + 17'd1;
  assign ack_base = (ack_inc > 17'(tot)) ? tot : SW'(ack_inc);
  assign idle_sat = (idle == 16'hFFFF) ? idle : idle + 16'd1;
  assign out_free = !m_tvalid || m_tready;

  // Sequencer: take one event, then send frames one per cycle while the output register is free.
  always_comb begin
    state_next  = state;
    base_next   = base;
    nxt_next    = nxt;
    idle_next   = idle;
    active_next = active;
    ev_pop      = 1'b0;
    load        = 1'b0;
    load_kind   = KIND_SEND;
    load_frame  = nxt;
    load_last   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (ev_valid) begin
          ev_pop = 1'b1;
          case (ev.op)
            OP_START: begin
              base_next   = '0;
              nxt_next    = '0;
              idle_next   = '0;
              active_next = 1'b1;
              state_next  = ST_EMIT;
            end
            OP_ACK: begin
              if (active) begin
                idle_next  = '0;
                state_next = ST_EMIT;
                if (ev.ack >= 16'(base)) begin
                  base_next = ack_base;
                  if (nxt < ack_base) begin
                    nxt_next = ack_base;
                  end
                end
              end
            end
            OP_TICK: begin
              if (active) begin
                state_next = ST_EMIT;
                if (idle_sat >= cfg.timeout_ticks) begin
                  nxt_next  = base;
                  idle_next = '0;
                end else begin
                  idle_next = idle_sat;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (base >= tot) begin
          // Transfer complete: one done result carrying the total.
          if (out_free) begin
            load        = 1'b1;
            load_kind   = KIND_DONE;
            load_frame  = tot;
            load_last   = 1'b1;
            active_next = 1'b0;
            state_next  = ST_IDLE;
          end
        end else if (({1'b0, nxt} < limit) && (nxt < tot)) begin
          if (out_free) begin
            load      = 1'b1;
            load_last = (nxt_inc >= limit) || (nxt_inc >= {1'b0, tot});
            nxt_next  = SW'(nxt_inc);
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register next values.
  always_comb begin
    o_valid_next = m_tvalid && !m_tready;
    o_data_next  = m_tdata;
    o_user_next  = m_tuser;
    o_last_next  = m_tlast;
    if (load) begin
      o_valid_next = 1'b1;
      o_data_next  = FrameW'(load_frame);
      o_user_next  = load_kind;
      o_last_next  = load_last;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      base     <= '0;
      nxt      <= '0;
      idle     <= '0;
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      base     <= base_next;
      nxt      <= nxt_next;
      idle     <= idle_next;
      active   <= active_next;
      m_tvalid <= o_valid_next;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    m_tdata <= o_data_next;
    m_tuser <= o_user_next;
    m_tlast <= o_last_next;
  end

endmodule

@@ rtl/go_back_n_sender_unit.sv @@
// Go-Back-N ARQ sender.
// The slave stream takes events: start a transfer, an ACK, or a timer tick.
// Each event may cause a burst of results on the master stream: one item per
// frame number to transmit, or a single done item once the window base
// reaches the total. tlast marks the final item of each burst; an event that
// causes nothing produces no item.
// Events pass through a two-entry queue into a sequencer. The sequencer
// takes an event, then sends its frames in order and returns to idle once it
// finds the window exhausted; a done item ends the transfer, and an event
// ignored while no transfer is active leaves the sequencer idle. The first
// result passes through the event queue, the sequencer state and the output
// register, and a burst streams one item per cycle while tready stays high.
// When the receiver holds tready low, the sequencer pauses with the result
// held and the queue fills; s_tready drops once two events are waiting.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Reset (rst, synchronous) empties the queue, clears the
// transfer state and restores window 4, total 10 and timeout 2.
module go_back_n_sender_unit
  import gbns_pkg::*;
#(
  parameter int SEQ_WIDTH  = 16,
  parameter int MAX_WINDOW = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // op [1:0], ack_number [17:2]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [FrameW-1:0]   m_tdata,   // frame_number [15:0]
  output logic                m_tuser,   // kind [0]
  output logic                m_tlast,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t   cfg;
  logic   ev_valid;
  event_t ev;
  logic   ev_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_limit     <= WindowSizeRst;
      cfg.frame_total   <= TotalFramesRst;
      cfg.timeout_ticks <= TimeoutTicksRst;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SIZE:   cfg.win_limit     <= cfg_data[WinRegW-1:0];
        REG_TOTAL_FRAMES:  cfg.frame_total   <= cfg_data;
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gbns_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .ev_valid (ev_valid),
    .ev       (ev),
    .ev_pop   (ev_pop)
  );

  gbns_back #(
    .SEQ_WIDTH  (SEQ_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .ev_valid (ev_valid),
    .ev       (ev),
    .ev_pop   (ev_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ rtl/gbns_checker.sv @@
module gbns_checker
  import gbns_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [FrameW-1:0]   m_tdata,
  input logic                m_tuser,
  input logic                m_tlast
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable({m_tdata, m_tuser, m_tlast}))
    else $error("result changed while stalled");

  // A done result always closes its burst.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_DONE) |-> m_tlast)
    else $error("done result without tlast");

  // Reset leaves no result pending.
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  // Reset leaves the event queue ready to accept.
  a_rst_in: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("event queue not empty after reset");

endmodule

bind go_back_n_sender_unit gbns_checker u_gbns_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import gbns_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned WindowCap = 64;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  // One event waiting to be driven into the block.
  typedef struct packed {
    logic [1:0]      op;
    logic [AckW-1:0] ack;
  } sender_event_t;

  // One expected result item: a frame to send or the done marker.
  typedef struct packed {
    logic              kind;
    logic [FrameW-1:0] frame;
    logic              last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [FrameW-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  sender_event_t pending_events[$];
  frame_result_t expected_frames[$];

  // Shadow copy of the configuration registers.
  logic [WinRegW-1:0] cfg_window = WindowSizeRst;
  logic [15:0] cfg_total = TotalFramesRst;
  logic [15:0] cfg_timeout = TimeoutTicksRst;

  // Predicted transfer state.
  logic [16:0] win_base = '0;
  logic [16:0] next_frame = '0;
  logic [15:0] idle_ticks = '0;
  logic xfer_active = 1'b0;

  // Approximate base used to steer the generated ACK numbers.
  int unsigned gen_base = 0;

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_hold = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  go_back_n_sender_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Window in force: zero behaves as one, anything above the cap is clipped.
  function automatic int unsigned window_in_force();
    if (cfg_window == 0) return 1;
    if (cfg_window > WindowCap) return WindowCap;
    return int'(cfg_window);
  endfunction

  // Works out the result items caused by one accepted event.
  function automatic void predict_frames(input logic [1:0] op, input logic [AckW-1:0] ack);
    logic [16:0] total;
    logic [16:0] stop;
    logic [16:0] new_base;
    int unsigned count;
    frame_result_t res;
    total = {1'b0, cfg_total};
    if (op == OP_START) begin
      win_base = '0;
      next_frame = '0;
      idle_ticks = '0;
      xfer_active = 1'b1;
    end else if (op == OP_UNDEFINED || !xfer_active) begin
      return;
    end else if (op == OP_ACK) begin
      idle_ticks = '0;
      if ({1'b0, ack} >= win_base) begin
        new_base = {1'b0, ack} + 17'd1;
        win_base = (new_base > total) ? total : new_base;
        if (next_frame < win_base) next_frame = win_base;
      end
    end else begin
      if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
      // A zero timeout fires on every tick, just as a timeout of one would.
      if (idle_ticks >= cfg_timeout) begin
        next_frame = win_base;
        idle_ticks = '0;
      end
    end
    // Base at the total: the transfer is complete.
    if (win_base >= total) begin
      res.kind = KIND_DONE;
      res.frame = cfg_total;
      res.last = 1'b1;
      expected_frames.push_back(res);
      xfer_active = 1'b0;
      return;
    end
    stop = win_base + 17'(window_in_force());
    if (total < stop) stop = total;
    count = (next_frame < stop) ? int'(stop - next_frame) : 0;
    if (count > WindowCap) count = WindowCap;
    for (int unsigned i = 0; i < count; i++) begin
      res.kind = KIND_SEND;
      res.frame = next_frame[15:0];
      res.last = (i == count - 1);
      expected_frames.push_back(res);
      next_frame = next_frame + 17'd1;
    end
  endfunction

  // Event driver: presents queued items with a random gap between them unless tx_calm is set.
  always @(posedge clk) begin
    sender_event_t ev;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_frames(s_tdata[1:0], s_tdata[17:2]);
      if (!(s_tvalid && !s_tready)) begin
        if (tx_gap != 0) begin
          s_tvalid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (pending_events.size() != 0) begin
          ev = pending_events.pop_front();
          s_tdata <= {6'b0, ev.ack, ev.op};
          s_tvalid <= 1'b1;
          tx_gap <= tx_calm ? 0 : $urandom_range(0, 7);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted item and stalls at random after it unless rx_calm is set.
  always @(posedge clk) begin
    frame_result_t exp_res;
    int unsigned stall;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
    end else if (m_tvalid && m_tready) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item: expected none, got kind %0d frame %0d last %0d",
                 $time, m_tuser, m_tdata, m_tlast);
      end else begin
        exp_res = expected_frames.pop_front();
        if (m_tuser !== exp_res.kind || m_tdata !== exp_res.frame
            || m_tlast !== exp_res.last) begin
          mismatches++;
          $display("%0t: mismatch: expected kind %0d frame %0d last %0d,",
                   $time, exp_res.kind, exp_res.frame, exp_res.last,
                   " got kind %0d frame %0d last %0d", m_tuser, m_tdata, m_tlast);
        end
      end
      stall = rx_calm ? 0 : $urandom_range(0, 7);
      rx_hold <= stall;
      m_tready <= (stall == 0);
    end else if (!m_tready) begin
      if (rx_hold <= 1) m_tready <= 1'b1;
      if (rx_hold != 0) rx_hold <= rx_hold - 1;
    end
  end

  // Hard limit on the length of the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic queue_event(input logic [1:0] op, input logic [AckW-1:0] ack);
    sender_event_t ev;
    ev.op = op;
    ev.ack = ack;
    pending_events.push_back(ev);
  endtask

  // Waits until every item has gone in and every result has come out.
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_events.size() != 0 || s_tvalid || expected_frames.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WINDOW_SIZE: cfg_window = val[WinRegW-1:0];
      REG_TOTAL_FRAMES: cfg_total = val;
      default: cfg_timeout = val;
    endcase
  endtask

  // Mostly well-formed transfers: a start, ACKs near the base and timer ticks,
  // with some stray ACK numbers, undefined events and restarts mixed in.
  task automatic run_transfers(input int unsigned count);
    int unsigned r;
    int unsigned span;
    int unsigned a;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      span = window_in_force();
      if (i == 0 || (gen_base >= cfg_total && r < 70) || r < 3) begin
        queue_event(OP_START, 16'($urandom));
        gen_base = 0;
      end else if (r < 70) begin
        if (r < 60)
          a = (gen_base == 0) ? $urandom_range(0, span - 1)
                              : gen_base - 1 + $urandom_range(0, span);
        else
          a = $urandom_range(0, 65535);
        a = a & 32'hFFFF;
        queue_event(OP_ACK, a[15:0]);
        if (a >= gen_base) gen_base = (a + 1 > cfg_total) ? cfg_total : a + 1;
      end else if (r < 95) begin
        queue_event(OP_TICK, 16'($urandom));
      end else begin
        queue_event(OP_UNDEFINED, 16'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [WinRegW-1:0] win, input logic [15:0] total,
                           input logic [15:0] tmo, input bit calm);
    wait_quiet();
    write_reg(REG_WINDOW_SIZE, {9'b0, win});
    write_reg(REG_TOTAL_FRAMES, total);
    write_reg(REG_TIMEOUT_TICKS, tmo);
    tx_calm = calm;
    rx_calm = calm;
    run_transfers(45);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset configuration: window 4, total 10, timeout 2.
    queue_event(OP_ACK, 16'd5);          // ignored while idle
    queue_event(OP_TICK, 16'd0);         // ignored while idle
    queue_event(OP_UNDEFINED, 16'd0);
    queue_event(OP_START, 16'd0);        // frames 0..3
    queue_event(OP_ACK, 16'd0);          // base 1, frame 4
    queue_event(OP_ACK, 16'd0);          // duplicate ACK
    queue_event(OP_TICK, 16'd0);
    queue_event(OP_TICK, 16'd0);         // timeout, resend from the base
    queue_event(OP_ACK, 16'd7);          // base jumps past the next frame
    queue_event(OP_START, 16'hFFFF);     // restart while active
    queue_event(OP_ACK, 16'd3);
    queue_event(OP_ACK, 16'hFFFF);       // base saturates at the total, done
    queue_event(OP_TICK, 16'hFFFF);      // ignored after done
    queue_event(OP_ACK, 16'd2);          // ignored after done
    queue_event(OP_UNDEFINED, 16'hFFFF);
    queue_event(OP_START, 16'd0);
    queue_event(OP_ACK, 16'd9);          // last frame acknowledged, done

    // Zero window and zero timeout, then the widest window and longest total.
    run_phase(7'd0, 16'd5, 16'd0, 1'b0);
    run_phase(7'd127, 16'd200, 16'd3, 1'b1);
    run_phase(7'd64, 16'hFFFF, 16'hFFFF, 1'b0);
    // A zero total completes on the start itself.
    run_phase(7'd1, 16'd0, 16'd1, 1'b0);
    run_phase(7'd7, 16'd30, 16'd4, 1'b1);
    run_phase(7'd3, 16'd1, 16'd1, 1'b0);

    wait_quiet();
    if (expected_frames.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gbns_pkg.sv
rtl/gbns_front.sv
rtl/gbns_back.sv
rtl/go_back_n_sender_unit.sv
rtl/gbns_checker.sv
tb/tb.sv
